// File: hdl/sem_pkg.sv
// Shared types, sizes and Sobel kernels of the RGB edge magnitude block.
// Depends on nothing; every other file of the block imports it.
package sem_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WEFF_W    = COL_W + 1;
   localparam int DIM_W     = 11;
   localparam int ROW_W     = DIM_W + 1;
   localparam int CH_W      = 8;
   localparam int NCH       = 3;
   localparam int PIX_W     = CH_W * NCH;
   localparam int LINE_W    = 2 * PIX_W;
   localparam int GRAD_W    = 11;
   localparam int SUMSQ_W   = 21;
   localparam int SAT_LIMIT = 64770;
   localparam int MAG_MAX   = 255;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam int KERN_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
   localparam int KERN_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic signed [GRAD_W-1:0] grad_type;

   typedef struct packed {
      logic load;
      logic col_zero;
      logic frame_end;
      logic top_zero;
      logic bot_zero;
   } win_ctl_type;

   // Channel 0 is red in the top byte, channel 2 is blue in the low byte.
   function automatic logic [CH_W-1:0] chan(input pix_type p, input int ch);
      chan = p[PIX_W-1-ch*CH_W -: CH_W];
   endfunction

endpackage

// File: hdl/sem_line_ram.sv
// Two line stores packed into one synchronous RAM: upper row in the top half, middle below.
// Depends on sem_pkg for sizes.
module sem_line_ram
   import sem_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [LINE_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [COL_W-1:0]  wr_addr,
   input  logic [LINE_W-1:0] wr_data
);

   logic [LINE_W-1:0] mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sem_window.sv
// 3x3 pixel window and the registered Sobel gradients of all three channels.
// Depends on sem_pkg for the kernels, pixel type and control struct.
module sem_window
   import sem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  win_ctl_type ctl,
   input  pix_type     top_pix,
   input  pix_type     mid_pix,
   input  pix_type     bot_pix,
   output grad_type    gx [NCH],
   output grad_type    gy [NCH]
);

   pix_type  win_ff [3][3];
   pix_type  win_in [3][3];
   pix_type  ew     [3][3];
   pix_type  col_in [3];
   grad_type gx_ff  [NCH];
   grad_type gy_ff  [NCH];
   grad_type gx_in  [NCH];
   grad_type gy_in  [NCH];

   assign col_in[0] = top_pix;
   assign col_in[1] = mid_pix;
   assign col_in[2] = bot_pix;

   // A row start first closes the previous row with a zero right column.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ew[i][0] = win_ff[i][1];
         ew[i][1] = win_ff[i][2];
         ew[i][2] = ctl.col_zero ? '0 : col_in[i];
         win_in[i][0] = ctl.col_zero ? '0 : win_ff[i][1];
         win_in[i][1] = ctl.col_zero ? '0 : win_ff[i][2];
         win_in[i][2] = ctl.frame_end ? '0 : col_in[i];
      end
   end

   always_comb begin
      int sx;
      int sy;
      int v;
      for (int ch = 0; ch < NCH; ch++) begin
         sx = 0;
         sy = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               v = int'(chan(ew[i][j], ch));
               if ((i == 0 && ctl.top_zero) || (i == 2 && ctl.bot_zero)) begin
                  v = 0;
               end
               sx = sx + KERN_X[i][j] * v;
               sy = sy + KERN_Y[i][j] * v;
            end
         end
         gx_in[ch] = GRAD_W'(sx);
         gy_in[ch] = GRAD_W'(sy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (ctl.load) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   assign gx = gx_ff;
   assign gy = gy_ff;

endmodule

// File: hdl/sem_root.sv
// Rounded, saturated gradient magnitude for three channels: squares, then a bit-serial root.
// Depends on sem_pkg for widths and the saturation limit.
module sem_root
   import sem_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  grad_type        gx   [NCH],
   input  grad_type        gy   [NCH],
   output logic [CH_W-1:0] mag  [NCH],
   output logic            done
);

   localparam logic [1:0] R_IDLE  = 2'd0;
   localparam logic [1:0] R_SQ    = 2'd1;
   localparam logic [1:0] R_ITER  = 2'd2;
   localparam logic [1:0] R_ROUND = 2'd3;

   logic [1:0]              phase_ff, phase_in;
   logic [$clog2(CH_W)-1:0] bit_ff, bit_in;
   logic                    done_ff, done_in;
   logic [SUMSQ_W-1:0]      s_ff   [NCH];
   logic [SUMSQ_W-1:0]      s_in   [NCH];
   logic [CH_W-1:0]         q_ff   [NCH];
   logic [CH_W-1:0]         q_in   [NCH];
   logic [CH_W-1:0]         mag_ff [NCH];
   logic [CH_W-1:0]         mag_in [NCH];

   always_comb begin
      logic signed [2*GRAD_W-1:0] px;
      logic signed [2*GRAD_W-1:0] py;
      logic [CH_W-1:0]            t;
      logic [2*CH_W-1:0]          tt;
      logic [2*CH_W:0]            qq;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      s_in     = s_ff;
      q_in     = q_ff;
      mag_in   = mag_ff;
      px = '0;
      py = '0;
      t  = '0;
      tt = '0;
      qq = '0;
      case (phase_ff)
         R_IDLE: begin
            if (start) begin
               phase_in = R_SQ;
            end
         end
         R_SQ: begin
            for (int ch = 0; ch < NCH; ch++) begin
               px = gx[ch] * gx[ch];
               py = gy[ch] * gy[ch];
               s_in[ch] = px[SUMSQ_W-1:0] + py[SUMSQ_W-1:0];
               q_in[ch] = '0;
            end
            bit_in   = '1;
            phase_in = R_ITER;
         end
         R_ITER: begin
            // One result bit per cycle, most significant first.
            for (int ch = 0; ch < NCH; ch++) begin
               t  = q_ff[ch] | (CH_W'(1) << bit_ff);
               tt = t * t;
               if (SUMSQ_W'(tt) <= s_ff[ch]) begin
                  q_in[ch] = t;
               end
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               phase_in = R_ROUND;
            end
         end
         R_ROUND: begin
            for (int ch = 0; ch < NCH; ch++) begin
               qq = (2*CH_W+1)'(q_ff[ch] * q_ff[ch]) + (2*CH_W+1)'(q_ff[ch]);
               if (s_ff[ch] > SUMSQ_W'(SAT_LIMIT)) begin
                  mag_in[ch] = CH_W'(MAG_MAX);
               end else if (s_ff[ch] > SUMSQ_W'(qq)) begin
                  mag_in[ch] = q_ff[ch] + 1'b1;
               end else begin
                  mag_in[ch] = q_ff[ch];
               end
            end
            done_in  = 1'b1;
            phase_in = R_IDLE;
         end
         default: begin
            phase_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      s_ff   <= s_in;
      q_ff   <= q_in;
      mag_ff <= mag_in;
   end

   assign mag  = mag_ff;
   assign done = done_ff;

endmodule

// File: hdl/sobel_edge_magnitude_rgb_top.sv
// Top level of the RGB Sobel edge magnitude block: sequencer, position counters, result register.
// Depends on sem_pkg, sem_line_ram, sem_window and sem_root.
//
// This block takes RGB pixels in raster order and returns, per pixel and per channel, the
// rounded Sobel gradient magnitude over its 3x3 neighborhood, saturated at 255, with
// neighbors outside the frame counted as zero. A result leaves one row plus one pixel after
// its own pixel, so after the last real pixel of a frame, image_width + 1 flush transfers
// (req_func high, pixel value ignored) drain it; the result for the frame's last pixel
// carries rsp_frame_last. An input transfer that yields no result (the first row and the
// first pixel of the second row) passes only through the accept and the RAM read. One that
// yields a result passes through a line RAM read, squaring, the shared bit-serial square
// root and rounding, the hand-over of the magnitudes, the load of the result register and
// the return to idle; a stalled result still in the result register adds its stall. The
// result register lets the next pixel enter while a finished result still waits on
// rsp_stall. Both line stores live in one RAM of MAX_WIDTH words of two pixels; its content
// needs no clearing after reset. The user writes width and height through the csr port
// only while the block is idle; the block itself does not enforce this. A width of zero
// acts as one, one above MAX_WIDTH as MAX_WIDTH, a height of zero as one.
module sobel_edge_magnitude_rgb_top
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_func,
   input  logic [CH_W-1:0]  req_red,
   input  logic [CH_W-1:0]  req_green,
   input  logic [CH_W-1:0]  req_blue,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CH_W-1:0]  rsp_edge_red,
   output logic [CH_W-1:0]  rsp_edge_green,
   output logic [CH_W-1:0]  rsp_edge_blue,
   output logic             rsp_frame_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_ROOT = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  addr_ff;
   pix_type           pix_ff;
   win_ctl_type       ctl_ff, ctl_in;
   logic              emit_ff, emit_in;
   logic              last_ff, last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_mag_ff [NCH];
   logic              rsp_last_ff;

   logic              req_accept;
   logic              rsp_load;
   logic [WEFF_W-1:0] w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [WEFF_W-1:0] col_next;

   logic [LINE_W-1:0] ram_rd_data;
   logic              ram_wr_en;
   win_ctl_type       win_ctl;
   grad_type          gx [NCH];
   grad_type          gy [NCH];
   logic [CH_W-1:0]   mag [NCH];
   logic              root_done;
   logic              root_start;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Position of the incoming pixel and what its transfer produces.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WEFF_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(width_ff);
      end
      h_eff = (height_ff == '0) ? ROW_W'(1) : ROW_W'(height_ff);

      // A row that became too short after a width change ends here.
      if ({1'b0, col_ff} >= w_eff) begin
         cur_col = '0;
         cur_row = row_ff + 1'b1;
      end else begin
         cur_col = col_ff;
         cur_row = row_ff;
      end

      ctl_in.load     = 1'b1;
      ctl_in.col_zero = (cur_col == '0);
      if (cur_col == '0) begin
         // Row start: emits the last pixel of the row two above.
         emit_in          = (cur_row >= ROW_W'(2)) && (cur_row < h_eff + ROW_W'(2));
         ctl_in.top_zero  = (cur_row == ROW_W'(2));
         ctl_in.bot_zero  = (cur_row >= h_eff + ROW_W'(1));
         last_in          = (cur_row == h_eff + ROW_W'(1));
         ctl_in.frame_end = (cur_row >= h_eff + ROW_W'(1));
      end else begin
         emit_in          = (cur_row >= ROW_W'(1)) && (cur_row < h_eff + ROW_W'(1));
         ctl_in.top_zero  = (cur_row == ROW_W'(1));
         ctl_in.bot_zero  = (cur_row >= h_eff);
         last_in          = 1'b0;
         ctl_in.frame_end = 1'b0;
      end

      col_next = {1'b0, cur_col} + 1'b1;
      if (ctl_in.frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (col_next >= w_eff) begin
         col_in = '0;
         row_in = cur_row + 1'b1;
      end else begin
         col_in = col_next[COL_W-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         addr_ff <= cur_col;
         pix_ff  <= req_func ? '0 : {req_red, req_green, req_blue};
         ctl_ff  <= ctl_in;
         emit_ff <= emit_in;
         last_ff <= last_in;
      end
   end

   // Sequencer: one pixel in flight from the RAM read to the result register.
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = emit_ff ? S_ROOT : S_IDLE;
         end
         S_ROOT: begin
            if (root_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Line stores: the RAM word read in the accept cycle is written back shifted one row up.
   assign ram_wr_en = (state_ff == S_READ) && !ctl_ff.frame_end;

   sem_line_ram u_line_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({ram_rd_data[PIX_W-1:0], pix_ff})
   );

   always_comb begin
      win_ctl      = ctl_ff;
      win_ctl.load = (state_ff == S_READ);
   end

   sem_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .top_pix (ram_rd_data[LINE_W-1:PIX_W]),
      .mid_pix (ram_rd_data[PIX_W-1:0]),
      .bot_pix (pix_ff),
      .gx      (gx),
      .gy      (gy)
   );

   assign root_start = (state_ff == S_READ) && emit_ff;

   sem_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .gx    (gx),
      .gy    (gy),
      .mag   (mag),
      .done  (root_done)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mag_ff  <= mag;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_red   = rsp_mag_ff[0];
   assign rsp_edge_green = rsp_mag_ff[1];
   assign rsp_edge_blue  = rsp_mag_ff[2];
   assign rsp_frame_last = rsp_last_ff;

   // A new result appears only out of the load state.
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result appeared outside the load state");

   // The root unit finishes only while the sequencer waits for it.
   a_root_done_wait : assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == S_ROOT)
      else $error("root unit finished while not awaited");

   // The drain transfer returns the positions to the frame start.
   a_frame_restart : assert property (@(posedge clock) disable iff (reset)
      req_accept && ctl_in.frame_end |=> col_ff == '0 && row_ff == '0)
      else $error("positions not reset after frame drain");

endmodule
